// ===== hw/rtl/b64e_pkg.sv =====
package b64e_pkg;

  localparam int LINE_LENGTH_RESET = 76;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_FULL = 2'd0;
  localparam logic [1:0] KIND_ONE  = 2'd1;
  localparam logic [1:0] KIND_TWO  = 2'd2;

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  kind;
    logic        crlf;
    logic        last;
  } b64e_cmd_t;

  function automatic logic [7:0] b64e_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/b64e_if.sv =====
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output out_char, output run_last, output message_end,
                  input ready);
  modport sink (input valid, input out_char, input run_last, input message_end,
                output ready);
endinterface

// ===== hw/rtl/b64e_front.sv =====
module b64e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        line_length,
  b64e_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              q_push,
  output b64e_pkg::b64e_cmd_t q_cmd
);
  import b64e_pkg::*;

  logic [15:0] held_r, held_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [8:0]  sum;
  logic        accept;
  logic        crlf;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && !q_full;
  assign sum = {1'b0, count_r} + 9'd4;
  assign crlf = sum >= {1'b0, line_length};

  always_comb begin
    held_nxt   = held_r;
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    q_push     = 1'b0;
    q_cmd.group = {held_r, in_ch.data_byte};
    q_cmd.kind  = KIND_FULL;
    q_cmd.crlf  = 1'b0;
    q_cmd.last  = in_ch.last_byte;
    if (phase_r == 2'd2) begin
      q_cmd.crlf = crlf;
    end else if (phase_r == 2'd1) begin
      q_cmd.kind  = KIND_TWO;
      q_cmd.group = {held_r[7:0], in_ch.data_byte, 8'h00};
    end else begin
      q_cmd.kind  = KIND_ONE;
      q_cmd.group = {in_ch.data_byte, 16'h0000};
    end
    if (accept) begin
      if (phase_r == 2'd2) begin
        q_push    = 1'b1;
        held_nxt  = 16'h0000;
        phase_nxt = 2'd0;
        count_nxt = crlf ? 8'd0 : sum[7:0];
      end else if (!in_ch.last_byte) begin
        held_nxt  = {held_r[7:0], in_ch.data_byte};
        phase_nxt = phase_r + 2'd1;
      end else begin
        q_push = 1'b1;
      end
      if (in_ch.last_byte) begin
        held_nxt  = 16'h0000;
        phase_nxt = 2'd0;
        count_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 16'h0000;
      phase_r <= 2'd0;
      count_r <= 8'd0;
    end else begin
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64e_pkg::b64e_cmd_t push_cmd,
  input  logic                pop,
  output logic                full,
  output logic                nonempty,
  output b64e_pkg::b64e_cmd_t head_cmd
);
  import b64e_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_cmd_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full = cnt_r == CW'(DEPTH);
  assign nonempty = cnt_r != '0;
  assign head_cmd = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/b64e_back.sv =====
module b64e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  b64e_pkg::b64e_cmd_t cmd,
  output logic                pop,
  b64e_out_if.source          out_ch
);
  import b64e_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       run_last_r, run_last_nxt;
  logic       end_r, end_nxt;
  logic       emit;
  logic       at_end;
  logic [7:0] ch;

  assign emit = cmd_valid && (!valid_r || out_ch.ready);
  assign at_end = cmd.crlf ? (idx_r == 3'd5) : (idx_r == 3'd3);
  assign pop = emit && at_end;

  always_comb begin
    unique case (idx_r)
      3'd0: ch = b64e_char(cmd.group[23:18]);
      3'd1: ch = b64e_char(cmd.group[17:12]);
      3'd2: ch = (cmd.kind == KIND_ONE) ? CHAR_PAD : b64e_char(cmd.group[11:6]);
      3'd3: ch = (cmd.kind == KIND_FULL) ? b64e_char(cmd.group[5:0]) : CHAR_PAD;
      3'd4: ch = CHAR_CR;
      default: ch = CHAR_LF;
    endcase
  end

  always_comb begin
    idx_nxt      = idx_r;
    valid_nxt    = valid_r;
    char_nxt     = char_r;
    run_last_nxt = run_last_r;
    end_nxt      = end_r;
    if (emit) begin
      valid_nxt    = 1'b1;
      char_nxt     = ch;
      run_last_nxt = at_end;
      end_nxt      = at_end && cmd.last;
      idx_nxt      = at_end ? 3'd0 : idx_r + 3'd1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    run_last_r <= run_last_nxt;
    end_r      <= end_nxt;
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.out_char    = char_r;
  assign out_ch.run_last    = run_last_r;
  assign out_ch.message_end = end_r;

endmodule

// ===== hw/rtl/base64_line_wrapped_encoder.sv =====
// MIME base64 encoder with CR LF line wrapping. Message bytes enter one per
// transaction on in_ch, with last_byte set on the final byte, and characters
// leave one per transaction on out_ch. The front accepts one byte per cycle
// while its command queue (QUEUE_DEPTH entries) has room, and the back emits
// one character per cycle while a command is queued and out_ch is not stalled,
// so a group of three bytes becomes four characters, or six when a CR LF line
// break follows it; the output side sets the sustained rate. Writing
// cfg_wdata with cfg_we high sets the line length, which resets to 76.
module base64_line_wrapped_encoder #(
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  b64e_in_if.sink    in_ch,
  b64e_out_if.source out_ch
);
  import b64e_pkg::*;

  logic [7:0] line_length_r;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_nonempty;
  b64e_cmd_t  q_in;
  b64e_cmd_t  q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= 8'(LINE_LENGTH_RESET);
    end else if (cfg_we) begin
      line_length_r <= cfg_wdata;
    end
  end

  b64e_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .line_length (line_length_r),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_in)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head_cmd (q_head)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_nonempty),
    .cmd       (q_head),
    .pop       (q_pop),
    .out_ch    (out_ch)
  );

endmodule
